// ===== hdl/pfw_pkg.sv =====
`timescale 1ns / 1ps

package pfw_pkg;

    localparam int FREQ_W        = 32;
    localparam int REF_W         = 26;
    localparam int CODE_W        = 6;
    localparam int INT_W         = 9;
    localparam int SEL_W         = 2;
    localparam int SHIFT_MAX     = 4;
    localparam int VCO_W         = FREQ_W + SHIFT_MAX;
    localparam int BAND_COUNT    = 16;
    localparam int FRAC_BITS_DEF = 23;

    localparam logic [REF_W-1:0]  REF_RESET     = 26'd38400000;
    localparam logic [CODE_W-1:0] FALLBACK_CODE = 6'h27;
    localparam logic [FREQ_W-1:0] SELECT_LIMIT  = 32'd1500000000;
    localparam logic [SEL_W-1:0]  SEL_LOW       = 2'd1;
    localparam logic [SEL_W-1:0]  SEL_HIGH      = 2'd2;

    typedef struct packed {
        logic [FREQ_W-1:0] lo;
        logic [FREQ_W-1:0] hi;
        logic [CODE_W-1:0] code;
    } t_band;

    localparam t_band BAND_TABLE [BAND_COUNT] = '{
        '{32'd232500000,  32'd285625000,  6'h27},
        '{32'd285625000,  32'd336875000,  6'h2f},
        '{32'd336875000,  32'd405000000,  6'h37},
        '{32'd405000000,  32'd465000000,  6'h3f},
        '{32'd465000000,  32'd571250000,  6'h26},
        '{32'd571250000,  32'd673750000,  6'h2e},
        '{32'd673750000,  32'd810000000,  6'h36},
        '{32'd810000000,  32'd930000000,  6'h3e},
        '{32'd930000000,  32'd1142500000, 6'h25},
        '{32'd1142500000, 32'd1347500000, 6'h2d},
        '{32'd1347500000, 32'd1620000000, 6'h35},
        '{32'd1620000000, 32'd1860000000, 6'h3d},
        '{32'd1860000000, 32'd2285000000, 6'h24},
        '{32'd2285000000, 32'd2695000000, 6'h2c},
        '{32'd2695000000, 32'd3240000000, 6'h34},
        '{32'd3240000000, 32'd3720000000, 6'h3c}
    };

    // operands into the shared compare/subtract unit
    typedef struct packed {
        logic [VCO_W-1:0] a;
        logic [VCO_W-1:0] b;
    } t_sub_req;

    typedef struct packed {
        logic             ge;
        logic [VCO_W-1:0] diff;
    } t_sub_res;

endpackage

// ===== hdl/pfw_band.sv =====
`timescale 1ns / 1ps

module pfw_band (
    input  logic [pfw_pkg::FREQ_W-1:0] i_freq,
    output logic [pfw_pkg::CODE_W-1:0] o_code
);
    import pfw_pkg::*;

    // walk downwards so the lowest matching band wins
    always_comb begin
        o_code = FALLBACK_CODE;
        for (int i = BAND_COUNT - 1; i >= 0; i--) begin
            if (i_freq > BAND_TABLE[i].lo && i_freq <= BAND_TABLE[i].hi) begin
                o_code = BAND_TABLE[i].code;
            end
        end
    end

endmodule

// ===== hdl/pfw_sub.sv =====
`timescale 1ns / 1ps

module pfw_sub (
    input  pfw_pkg::t_sub_req i_req,
    output pfw_pkg::t_sub_res o_res
);
    import pfw_pkg::*;

    logic [VCO_W:0] w_diff;

    assign w_diff      = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_res.ge    = ~w_diff[VCO_W];
    assign o_res.diff  = w_diff[VCO_W-1:0];

endmodule

// ===== hdl/pll_frequency_word_calc.sv =====
`timescale 1ns / 1ps

// An accepted item passes S_BAND, S_PRE and S_SAT, then S_INT and S_FRAC; o_strobe is
// registered, and rises after S_SAT when the ratio saturates or the reference is zero.
// A new item is taken only while idle, after the last result is shown; the restoring
// divider takes one quotient bit a cycle through a single shared compare/subtract unit.
// busy falls as the result is shown, so the next item can be taken in the strobe cycle.
// The receiver cannot stall. Synchronous active-low reset idles the block, ref 38.4 MHz.
module pll_frequency_word_calc #(
    parameter int FRAC_BITS = pfw_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pfw_pkg::FREQ_W-1:0]   i_freq_hz,
    input  logic                         i_cfg_we,
    input  logic [pfw_pkg::REF_W-1:0]    i_cfg_wdata,
    output logic                         o_strobe,
    output logic [pfw_pkg::CODE_W-1:0]   o_band_code,
    output logic [pfw_pkg::INT_W-1:0]    o_int_divider,
    output logic [FRAC_BITS-1:0]         o_frac_divider,
    output logic [pfw_pkg::SEL_W-1:0]    o_out_select
);
    import pfw_pkg::*;

    localparam int Q_W   = INT_W + FRAC_BITS;
    localparam int CNT_W = $clog2(FRAC_BITS > INT_W ? FRAC_BITS : INT_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BAND,
        S_PRE,
        S_SAT,
        S_INT,
        S_FRAC
    } t_state;

    t_state              r_state;
    logic [REF_W-1:0]    r_ref;
    logic [FREQ_W-1:0]   r_f;
    logic [CODE_W-1:0]   r_code;
    logic [SEL_W-1:0]    r_sel;
    logic [VCO_W-1:0]    r_rem;
    logic [VCO_W-1:0]    r_div;
    logic [CNT_W-1:0]    r_cnt;
    logic [Q_W-1:0]      r_q;
    logic                r_strobe;
    logic [CODE_W-1:0]   r_out_code;
    logic [INT_W-1:0]    r_out_int;
    logic [FRAC_BITS-1:0] r_out_frac;
    logic [SEL_W-1:0]    r_out_sel;

    logic [CODE_W-1:0]   w_code;
    logic [2:0]          w_shift;
    logic [VCO_W-1:0]    w_vco;
    t_sub_req            w_req;
    t_sub_res            w_res;
    logic [VCO_W-1:0]    w_rem_next;
    logic [Q_W-1:0]      w_q_next;

    pfw_band u_band (
        .i_freq (r_f),
        .o_code (w_code)
    );

    pfw_sub u_sub (
        .i_req (w_req),
        .o_res (w_res)
    );

    // prescale 2^(code[2:0]-3): a shift of 1..4 for every table code
    assign w_shift = r_code[2:0] - 3'd3;
    assign w_vco   = {{SHIFT_MAX{1'b0}}, r_f} << w_shift;

    always_comb begin
        if (r_state == S_FRAC) begin
            w_req.a = {r_rem[VCO_W-2:0], 1'b0};
            w_req.b = VCO_W'(r_ref);
        end else begin
            w_req.a = r_rem;
            w_req.b = r_div;
        end
        w_rem_next = w_res.ge ? w_res.diff : w_req.a;
        w_q_next   = {r_q[Q_W-2:0], w_res.ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ref    <= REF_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_ref <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_f     <= i_freq_hz;
                        r_state <= S_BAND;
                    end
                end
                S_BAND: begin
                    r_code  <= w_code;
                    r_sel   <= (r_f < SELECT_LIMIT) ? SEL_LOW : SEL_HIGH;
                    r_state <= S_PRE;
                end
                S_PRE: begin
                    r_rem   <= w_vco;
                    r_div   <= VCO_W'(r_ref) << INT_W;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    // quotient above the integer range, or no reference: saturate
                    if (w_res.ge || r_ref == '0) begin
                        r_out_code <= r_code;
                        r_out_sel  <= r_sel;
                        r_out_int  <= '1;
                        r_out_frac <= '1;
                        r_strobe   <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_div   <= r_div >> 1;
                        r_cnt   <= CNT_W'(INT_W - 1);
                        r_q     <= '0;
                        r_state <= S_INT;
                    end
                end
                S_INT: begin
                    r_rem <= w_rem_next;
                    r_q   <= w_q_next;
                    r_div <= r_div >> 1;
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(FRAC_BITS - 1);
                        r_state <= S_FRAC;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_FRAC: begin
                    r_rem <= w_rem_next;
                    r_q   <= w_q_next;
                    if (r_cnt == '0) begin
                        r_out_code <= r_code;
                        r_out_sel  <= r_sel;
                        r_out_int  <= w_q_next[Q_W-1:FRAC_BITS];
                        r_out_frac <= w_q_next[FRAC_BITS-1:0];
                        r_strobe   <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_band_code    = r_out_code;
    assign o_int_divider  = r_out_int;
    assign o_frac_divider = r_out_frac;
    assign o_out_select   = r_out_sel;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not make the block busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result shown without an item in work");

    a_select_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_out_select == SEL_LOW || o_out_select == SEL_HIGH))
        else $error("output select code out of range");

endmodule

// ===== sim/pfw_checker.sv =====
`timescale 1ns / 1ps

module pfw_checker #(
    parameter int FRAC_BITS = pfw_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [pfw_pkg::FREQ_W-1:0]   i_freq_hz,
    input  logic                         i_cfg_we,
    input  logic [pfw_pkg::REF_W-1:0]    i_cfg_wdata,
    input  logic                         o_strobe,
    input  logic [pfw_pkg::CODE_W-1:0]   o_band_code,
    input  logic [pfw_pkg::INT_W-1:0]    o_int_divider,
    input  logic [FRAC_BITS-1:0]         o_frac_divider,
    input  logic [pfw_pkg::SEL_W-1:0]    o_out_select,
    output int                           o_fail_count,
    output int                           o_pending
);
    import pfw_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0]    band;
        logic [INT_W-1:0]     whole;
        logic [FRAC_BITS-1:0] frac;
        logic [SEL_W-1:0]     sel;
    } t_pll_word;

    // band i covers EDGE_HZ[i] < f <= EDGE_HZ[i+1]
    localparam bit [31:0] EDGE_HZ [17] = '{
        32'd232500000,  32'd285625000,  32'd336875000,  32'd405000000,
        32'd465000000,  32'd571250000,  32'd673750000,  32'd810000000,
        32'd930000000,  32'd1142500000, 32'd1347500000, 32'd1620000000,
        32'd1860000000, 32'd2285000000, 32'd2695000000, 32'd3240000000,
        32'd3720000000
    };
    localparam bit [5:0] BAND_CODES [16] = '{
        6'h27, 6'h2f, 6'h37, 6'h3f, 6'h26, 6'h2e, 6'h36, 6'h3e,
        6'h25, 6'h2d, 6'h35, 6'h3d, 6'h24, 6'h2c, 6'h34, 6'h3c
    };

    logic [REF_W-1:0] ref_hz;
    t_pll_word        words_due [$];
    int               fails;

    assign o_fail_count = fails;

    function automatic t_pll_word calc_pll_word(input bit [31:0] f, input bit [25:0] div_hz);
        t_pll_word   w;
        bit [63:0]   vco;
        bit [63:0]   q;
        bit [63:0]   rem;
        int unsigned shift;
        w.band = FALLBACK_CODE;
        for (int i = 0; i < 16; i++) begin
            if (f > EDGE_HZ[i] && f <= EDGE_HZ[i+1]) w.band = BAND_CODES[i];
        end
        shift = w.band[2:0] - 3;
        w.whole = '1;
        w.frac  = '1;
        // zero reference behaves like a divide by zero: saturated word
        if (div_hz != 0) begin
            vco = 64'(f) << shift;
            q   = vco / div_hz;
            if (q <= 511) begin
                rem     = vco - q * div_hz;
                w.whole = q[INT_W-1:0];
                w.frac  = FRAC_BITS'((rem << FRAC_BITS) / div_hz);
            end
        end
        w.sel = (f < SELECT_LIMIT) ? SEL_LOW : SEL_HIGH;
        return w;
    endfunction

    initial begin
        fails     = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin : watch
        t_pll_word want;
        if (!i_rst_n) begin
            ref_hz <= REF_RESET;
        end else begin
            if (o_strobe) begin
                if (words_due.size() == 0) begin
                    $error("result with no item outstanding");
                    fails++;
                end else begin
                    want = words_due.pop_front();
                    if (o_band_code !== want.band) begin
                        $error("band_code: expected %0h, actual %0h", want.band, o_band_code);
                        fails++;
                    end
                    if (o_int_divider !== want.whole) begin
                        $error("int_divider: expected %0d, actual %0d",
                               want.whole, o_int_divider);
                        fails++;
                    end
                    if (o_frac_divider !== want.frac) begin
                        $error("frac_divider: expected %0h, actual %0h",
                               want.frac, o_frac_divider);
                        fails++;
                    end
                    if (o_out_select !== want.sel) begin
                        $error("out_select: expected %0d, actual %0d", want.sel, o_out_select);
                        fails++;
                    end
                end
            end
            if (start && !busy) words_due.push_back(calc_pll_word(i_freq_hz, ref_hz));
            if (i_cfg_we) ref_hz <= i_cfg_wdata;
        end
        o_pending <= words_due.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pfw_pkg::*;

    localparam int FRAC_BITS  = FRAC_BITS_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_ITEMS = 140;

    localparam bit [31:0] SPOT_FREQS [20] = '{
        32'd0,          32'd1,          32'hFFFFFFFF,   32'd232500000,
        32'd232500001,  32'd285625000,  32'd285625001,  32'd3720000000,
        32'd3720000001, 32'd1499999999, 32'd1500000000, 32'd1347500000,
        32'd1620000000, 32'd1620000001, 32'h80000000,   32'h55555555,
        32'hAAAAAAAA,   32'd2285000000, 32'd930000000,  32'd930000001
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [FREQ_W-1:0]    i_freq_hz;
    logic                 i_cfg_we;
    logic [REF_W-1:0]     i_cfg_wdata;
    logic                 o_strobe;
    logic [CODE_W-1:0]    o_band_code;
    logic [INT_W-1:0]     o_int_divider;
    logic [FRAC_BITS-1:0] o_frac_divider;
    logic [SEL_W-1:0]     o_out_select;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles;

    pll_frequency_word_calc #(.FRAC_BITS(FRAC_BITS)) dut (.*);

    pfw_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog: too long without an item or a result going through
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    // mostly in-band, some band edges, some around the select threshold, rest anything
    function automatic bit [31:0] pick_freq();
        int        r;
        int        b;
        bit [31:0] lo;
        bit [31:0] hi;
        r  = $urandom_range(0, 99);
        b  = $urandom_range(0, BAND_COUNT - 1);
        lo = BAND_TABLE[b].lo;
        hi = BAND_TABLE[b].hi;
        if (r < 60) return $urandom_range(hi, lo + 1);
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0: return lo;
                1: return lo + 1;
                2: return hi;
                default: return hi + 1;
            endcase
        end
        if (r < 80) return SELECT_LIMIT + $urandom_range(0, 4) - 2;
        return $urandom;
    endfunction

    task automatic send_item(input bit [31:0] f, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start     <= 1'b1;
        i_freq_hz <= f;
        do @(posedge i_clk); while (!(start && !busy));
    endtask

    task automatic end_phase();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_ref(input bit [REF_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stim
        bit [REF_W-1:0] div_hz;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_freq_hz   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed items at the reset reference
        foreach (SPOT_FREQS[k]) send_item(SPOT_FREQS[k], (k % 3 == 0) ? 2 : 0);
        end_phase();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: div_hz = 26'd20000000;
                1: div_hz = 26'd52000000;
                2: div_hz = '0;
                3: div_hz = '1;
                4: div_hz = 26'd1;
                5: div_hz = $urandom_range(52000000, 20000000);
                6: div_hz = $urandom;
                default: div_hz = REF_RESET;
            endcase
            write_ref(div_hz);
            // first stretch of each phase runs back to back
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(pick_freq(), (n < 20) ? 0 : pick_gap());
            end
            end_phase();
        end

        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
